FILE: sv/dsa_pkg.sv
// Shared types and constants for the deadline slot allocator.
`default_nettype none

package dsa_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int DL_W   = 16;
  localparam int SC_W   = 16;
  localparam int TOT_W  = 26;

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LIMIT_INIT = SLOT_W'(1024);
  localparam logic [TOT_W-1:0]  TOTAL_MAX  = {TOT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRD,
    ST_FCHK,
    ST_CRD,
    ST_CWR,
    ST_LINK
  } state_t;

  // One access to the parent table per cycle: write when we, else read.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } tbl_req_t;

  typedef struct packed {
    logic              strobe;
    logic              accepted;
    logic [SLOT_W-1:0] slot;
  } job_done_t;

endpackage

`default_nettype wire

FILE: sv/dsa_table.sv
// Parent table memory: one port, one access per cycle, registered read data.
`default_nettype none

module dsa_table (
  input  wire                        clk,
  input  wire dsa_pkg::tbl_req_t     req,
  output logic [dsa_pkg::SLOT_W-1:0] rdata
);
  import dsa_pkg::*;

  logic [SLOT_W-1:0] mem [0:SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end else begin
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsa_seq.sv
// Sequencer: clearing pass, find walk, path compression and slot link.
`default_nettype none

module dsa_seq (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  input  wire  [dsa_pkg::DL_W-1:0]   deadline,
  input  wire  [dsa_pkg::SLOT_W-1:0] slot_limit,
  output logic                       busy,
  output dsa_pkg::tbl_req_t          tbl_req,
  input  wire  [dsa_pkg::SLOT_W-1:0] tbl_rdata,
  output dsa_pkg::job_done_t         done
);
  import dsa_pkg::*;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [SLOT_W-1:0] x_r, x_nxt;       // clamped deadline
  logic [SLOT_W-1:0] walk_r, walk_nxt; // find cursor, then compress cursor
  logic [SLOT_W-1:0] root_r, root_nxt;
  logic [SLOT_W-1:0] lim;
  logic [SLOT_W-1:0] x_clamp;

  // Saturate the limit at the table size, then clamp the deadline to it.
  always_comb begin
    lim     = (slot_limit > SLOT_LAST) ? SLOT_LAST : slot_limit;
    x_clamp = (deadline > {{(DL_W-SLOT_W){1'b0}}, lim}) ? lim : deadline[SLOT_W-1:0];
  end

  // Next state and datapath registers.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    x_nxt     = x_r;
    walk_nxt  = walk_r;
    root_nxt  = root_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          x_nxt     = x_clamp;
          walk_nxt  = x_clamp;
          state_nxt = ST_FRD;
        end
      end
      ST_FRD:  state_nxt = ST_FCHK;
      ST_FCHK: begin
        if (tbl_rdata == walk_r) begin
          root_nxt  = walk_r;
          walk_nxt  = x_r;
          state_nxt = ST_CRD;
        end else begin
          walk_nxt  = tbl_rdata;
          state_nxt = ST_FRD;
        end
      end
      ST_CRD: begin
        state_nxt = (walk_r == root_r) ? ST_LINK : ST_CWR;
      end
      ST_CWR: begin
        walk_nxt  = tbl_rdata;
        state_nxt = ST_CRD;
      end
      ST_LINK: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: table access, busy and completion.
  always_comb begin
    tbl_req       = '0;
    busy          = 1'b1;
    done          = '0;
    unique case (state_r)
      ST_CLEAR: begin
        tbl_req.we    = 1'b1;
        tbl_req.addr  = clr_r;
        tbl_req.wdata = clr_r;
      end
      ST_IDLE: busy = 1'b0;
      ST_FRD:  tbl_req.addr = walk_r;
      ST_FCHK: tbl_req.addr = walk_r;
      ST_CRD:  tbl_req.addr = walk_r;
      ST_CWR: begin
        tbl_req.we    = 1'b1;
        tbl_req.addr  = walk_r;
        tbl_req.wdata = root_r;
      end
      ST_LINK: begin
        tbl_req.addr  = root_r;
        tbl_req.wdata = root_r - SLOT_W'(1);
        tbl_req.we    = (root_r != '0);
        done.strobe   = 1'b1;
        done.accepted = (root_r != '0);
        done.slot     = root_r;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    walk_r <= walk_nxt;
    root_r <= root_nxt;
  end

endmodule

`default_nettype wire

FILE: sv/deadline_slot_allocator.sv
// Top level of the deadline slot allocator: limit register, score total, result words.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------------
//   input   | in_deadline, in_score                   | taken when start & !busy
//   result  | out_accepted, out_slot, out_total       | out_valid for one cycle
//   config  | cfg_wdata                               | written when cfg_we
//
// Sequence: a job keeps busy high through a read and a check state per table read in
// the find walk, a read and a write state per compressed entry, and the link state; its
// result word appears as busy falls. The single-port parent table sets this pace.
// Reset: a clearing pass writes the identity into all SLOTS+1 = 1025 table entries;
// busy stays high meanwhile, configuration writes are still taken.
// Stalls: the receiver cannot stall; each result word is shown for exactly one cycle.
`default_nettype none

module deadline_slot_allocator (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  wire  [dsa_pkg::DL_W-1:0]   in_deadline,
  input  wire  [dsa_pkg::SC_W-1:0]   in_score,
  output logic                       out_valid,
  output logic                       out_accepted,
  output logic [dsa_pkg::SLOT_W-1:0] out_slot,
  output logic [dsa_pkg::TOT_W-1:0]  out_total,
  input  wire                        cfg_we,
  input  wire  [dsa_pkg::SLOT_W-1:0] cfg_wdata
);
  import dsa_pkg::*;

  logic [SLOT_W-1:0] limit_r;
  logic [SC_W-1:0]   score_r;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W:0]    total_sum;
  logic              valid_r;
  logic              acc_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] tbl_rdata;
  tbl_req_t          tbl_req;
  job_done_t         done;

  dsa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .deadline  (in_deadline),
    .slot_limit(limit_r),
    .busy      (busy),
    .tbl_req   (tbl_req),
    .tbl_rdata (tbl_rdata),
    .done      (done)
  );

  dsa_table u_table (
    .clk  (clk),
    .req  (tbl_req),
    .rdata(tbl_rdata)
  );

  // Add the score of an accepted job, saturating at the widest total the port shows.
  always_comb begin
    total_sum = {1'b0, total_r} + {{(TOT_W+1-SC_W){1'b0}}, score_r};
    total_nxt = total_r;
    if (done.strobe && done.accepted) begin
      total_nxt = total_sum[TOT_W] ? TOTAL_MAX : total_sum[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_INIT;
      total_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      total_r <= total_nxt;
      valid_r <= done.strobe;
    end
  end

  // Hold the score of the job in flight; capture the result word on completion.
  always_ff @(posedge clk) begin
    if (start && !busy) score_r <= in_score;
    if (done.strobe) begin
      acc_r  <= done.accepted;
      slot_r <= done.slot;
    end
  end

  assign out_valid    = valid_r;
  assign out_accepted = acc_r;
  assign out_slot     = slot_r;
  assign out_total    = total_r;

endmodule

`default_nettype wire

FILE: test/slot_grant_checker.sv
// Checker for the deadline slot allocator: mirrors the slot table and checks every result word.
`timescale 1ns / 1ps

module slot_grant_checker
  import dsa_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              busy,
  input  wire [DL_W-1:0]   in_deadline,
  input  wire [SC_W-1:0]   in_score,
  input  wire              out_valid,
  input  wire              out_accepted,
  input  wire [SLOT_W-1:0] out_slot,
  input  wire [TOT_W-1:0]  out_total,
  input  wire              cfg_we,
  input  wire [SLOT_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               words_owed
);

  typedef struct packed {
    logic              accepted;
    logic [SLOT_W-1:0] slot;
    logic [TOT_W-1:0]  total;
  } grant_t;

  logic [SLOT_W-1:0] slot_parent [0:SLOTS];
  logic [TOT_W:0]    score_sum;
  logic [SLOT_W-1:0] limit_reg;
  grant_t            pending_grants[$];
  int                faults;

  // Latest free slot at or below the clamped deadline, with path compression.
  function automatic grant_t grant_job(input logic [DL_W-1:0] deadline,
                                       input logic [SC_W-1:0] score);
    int unsigned eff, first, root, walk, nxt;
    grant_t      g;
    eff   = (limit_reg > SLOT_LAST) ? SLOTS : 32'(limit_reg);
    first = (32'(deadline) > eff) ? eff : 32'(deadline);
    root  = first;
    while (32'(slot_parent[root]) != root)
      root = 32'(slot_parent[root]);
    walk = first;
    while (walk != root) begin
      nxt               = 32'(slot_parent[walk]);
      slot_parent[walk] = SLOT_W'(root);
      walk              = nxt;
    end
    g.accepted = (root != 0);
    g.slot     = SLOT_W'(root);
    if (root != 0) begin
      slot_parent[root] = SLOT_W'(root - 1);
      score_sum         = score_sum + (TOT_W+1)'(score);
      if (score_sum > {1'b0, TOTAL_MAX})
        score_sum = {1'b0, TOTAL_MAX};
    end
    g.total = score_sum[TOT_W-1:0];
    return g;
  endfunction

  task automatic note_fault(input string msg);
    if (faults < 10)
      $display("%0t: %s", $realtime, msg);
    faults++;
  endtask

  always @(posedge clk) begin
    grant_t got, want;
    if (!rst_n) begin
      for (int i = 0; i <= SLOTS; i++)
        slot_parent[i] = SLOT_W'(i);
      score_sum = '0;
      limit_reg = LIMIT_INIT;
      faults    = 0;
      pending_grants.delete();
    end else begin
      if (cfg_we)
        limit_reg = cfg_wdata;
      // Retire the result word before taking a new job in the same cycle.
      if (out_valid) begin
        got.accepted = out_accepted;
        got.slot     = out_slot;
        got.total    = out_total;
        if (pending_grants.size() == 0) begin
          note_fault($sformatf("unexpected word: accepted=%0d slot=%0d total=%0d",
                               got.accepted, got.slot, got.total));
        end else begin
          want = pending_grants.pop_front();
          if (got != want)
            note_fault($sformatf({"mismatch: expected accepted=%0d slot=%0d total=%0d,",
                                  " got accepted=%0d slot=%0d total=%0d"},
                                 want.accepted, want.slot, want.total,
                                 got.accepted, got.slot, got.total));
        end
      end
      if (start && !busy)
        pending_grants.push_back(grant_job(in_deadline, in_score));
    end
    fail_count <= faults;
    words_owed <= pending_grants.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the deadline slot allocator testbench: clock, reset, job stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import dsa_pkg::*;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              start       = 1'b0;
  logic [DL_W-1:0]   in_deadline = '0;
  logic [SC_W-1:0]   in_score    = '0;
  logic              cfg_we      = 1'b0;
  logic [SLOT_W-1:0] cfg_wdata   = '0;
  logic              busy;
  logic              out_valid;
  logic              out_accepted;
  logic [SLOT_W-1:0] out_slot;
  logic [TOT_W-1:0]  out_total;
  int                fail_count;
  int                words_owed;
  bit                steady      = 1'b0;  // set: sender never pauses

  always #10 clk = ~clk;

  deadline_slot_allocator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_deadline  (in_deadline),
    .in_score     (in_score),
    .out_valid    (out_valid),
    .out_accepted (out_accepted),
    .out_slot     (out_slot),
    .out_total    (out_total),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  slot_grant_checker check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_deadline  (in_deadline),
    .in_score     (in_score),
    .out_valid    (out_valid),
    .out_accepted (out_accepted),
    .out_slot     (out_slot),
    .out_total    (out_total),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .words_owed   (words_owed)
  );

  // Offer one job word and hold it until the block takes it. A random pause before the
  // offer lands on whatever phase of the walk the block is in; start stays high between
  // back-to-back words, so it is never lowered and raised within one step.
  task automatic send_job(input logic [DL_W-1:0] deadline, input logic [SC_W-1:0] score);
    if (!steady && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start       <= 1'b1;
    in_deadline <= deadline;
    in_score    <= score;
    do @(posedge clk); while (busy);
  endtask

  // Drain every owed word, let the block settle, then write the limit register.
  task automatic set_limit(input logic [SLOT_W-1:0] value);
    start <= 1'b0;
    do @(posedge clk); while (busy || words_owed != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random jobs under one limit: mostly in-range deadlines, a cluster around one hot
  // slot to build long chains for compression, and clamped or zero deadlines besides.
  // Scores mostly fall, as a sorted feed would, with full-range noise mixed in.
  task automatic run_phase(input logic [SLOT_W-1:0] limit, input int count);
    int unsigned eff, hot, pick, dl, level, sc;
    eff   = (limit > SLOT_LAST) ? SLOTS : 32'(limit);
    hot   = (eff == 0) ? 0 : $urandom_range(1, eff);
    level = 65535;
    set_limit(limit);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        dl = (eff == 0) ? 0 : $urandom_range(1, eff);
      else if (pick < 75)
        dl = hot + $urandom_range(0, 4);
      else if (pick < 87)
        dl = $urandom_range(0, 65535);
      else if (pick < 93)
        dl = 0;
      else
        dl = 65535;
      if ($urandom_range(0, 9) < 7) begin
        level = (level < 400) ? 65535 : level - $urandom_range(0, 400);
        sc    = level;
      end else begin
        sc = $urandom_range(0, 65535);
      end
      send_job(DL_W'(dl), SC_W'(sc));
    end
  endtask

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit of 1024: zero deadline, top slot, clamped deadlines, a filled chain.
    send_job(16'd0, 16'hFFFF);
    send_job(16'd1, 16'hFFFF);
    send_job(16'd1, 16'd40000);
    send_job(16'hFFFF, 16'd30000);
    send_job(16'd1024, 16'd20000);
    send_job(16'd1025, 16'd1);
    send_job(16'd3, 16'd0);
    send_job(16'd3, 16'd0);
    send_job(16'd3, 16'd5);
    send_job(16'd4, 16'd7);
    send_job(16'd4, 16'd6);

    // Zero limit: everything is turned away.
    set_limit(11'd0);
    send_job(16'd500, 16'd9);
    send_job(16'hFFFF, 16'd9);

    // Limit above the table size saturates at the top slot.
    set_limit(11'h7FF);
    send_job(16'd2047, 16'hFFFF);
    send_job(16'd1024, 16'h8000);

    // Limit of one with slot 1 already gone; the table survives the change.
    set_limit(11'd1);
    send_job(16'd1, 16'h00FF);
    send_job(16'hFFFF, 16'hFF00);

    set_limit(11'd16);
    send_job(16'd16, 16'h5555);
    send_job(16'd16, 16'hAAAA);
    send_job(16'd16, 16'h1234);
    send_job(16'd9, 16'h4321);
    send_job(16'hFFFF, 16'h0F0F);
    start <= 1'b0;

    run_phase(11'd64, 50);
    steady = 1'b1;
    run_phase(11'd1024, 60);
    steady = 1'b0;
    run_phase(11'h7FF, 50);
    run_phase(11'd200, 40);
    run_phase(11'd1, 20);
    for (int p = 0; p < 4; p++)
      run_phase(SLOT_W'($urandom_range(1, 2047)), 45);

    // Drain what is owed, then give a late word time to turn up.
    start <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && words_owed == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
